[design/spq2_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spq2_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int HANDLE_W  = 16;
   localparam int PORT_W    = 16;
   localparam int RAND_W    = 16;
   localparam int PROB_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_B = 3'd3;

   // Register reset values
   localparam logic [PORT_W-1:0] PORT_A_RESET = 16'd4000;
   localparam logic [PORT_W-1:0] PORT_B_RESET = 16'd5000;
   localparam logic [PROB_W-1:0] PROB_ONE     = 17'd65536;

   // Command and class codes
   localparam logic CMD_ENQ   = 1'b0;
   localparam logic CMD_DEQ   = 1'b1;
   localparam logic CLS_HIGH  = 1'b0;
   localparam logic CLS_LOW   = 1'b1;

   // Queue control toward one FIFO
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   // Queue status back from one FIFO
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

`default_nettype wire

[design/spq2_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  wire logic [WIDTH-1:0]               wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic      [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/spq2_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq2_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire spq2_pkg::fifo_ctl_type        ctl,
   input  wire logic [spq2_pkg::HANDLE_W-1:0] wr_handle,
   output spq2_pkg::fifo_stat_type            stat,
   output logic      [spq2_pkg::HANDLE_W-1:0] rd_handle
);

   logic [spq2_pkg::PTR_W-1:0] head_ff, head_in;
   logic [spq2_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [spq2_pkg::CNT_W-1:0] count_ff, count_in;

   // Wrapping pointer advance
   function automatic logic [spq2_pkg::PTR_W-1:0] ptr_next(
      input logic [spq2_pkg::PTR_W-1:0] p
   );
      logic [spq2_pkg::PTR_W-1:0] last;
      last = spq2_pkg::PTR_W'(spq2_pkg::QUEUE_DEPTH - 1);
      return (p == last) ? '0 : p + 1'b1;
   endfunction

   // Slot storage: write at tail on push, read at head on pop
   spq2_ram #(
      .WIDTH (spq2_pkg::HANDLE_W),
      .DEPTH (spq2_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (wr_handle),
      .rd_en   (ctl.pop),
      .rd_addr (head_ff),
      .rd_data (rd_handle)
   );

   // Pointer and count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in = ptr_next(tail_ff);
      end
      if (ctl.pop) begin
         head_in = ptr_next(head_ff);
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == spq2_pkg::CNT_W'(spq2_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

[design/strict_priority_two_class_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// request   start / busy              req_cmd, req_packet_handle, req_dest_port,
//                                     req_rand_value
// response  rsp_strobe (one cycle)    rsp_accepted, rsp_class_index, rsp_out_valid,
//                                     rsp_out_handle
// register  csr_valid / csr_ready     csr_index, csr_data
//
// The response appears in the cycle after acceptance.
// Beats may be issued every cycle when not busy: the FIFO RAMs are written and
// read at the accept edge, so a later beat always sees the previous one's pointers
// and data. The response cycle is set by the registered read of the FIFO RAMs.
// Reset is synchronous; busy is high during reset and the cycle after it.
// The FIFO RAMs are not cleared; only pointers and counts reset.
// The response side cannot stall: the strobe is never held.

module strict_priority_two_class_queue_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_cmd,
   input  wire logic [spq2_pkg::HANDLE_W-1:0]  req_packet_handle,
   input  wire logic [spq2_pkg::PORT_W-1:0]    req_dest_port,
   input  wire logic [spq2_pkg::RAND_W-1:0]    req_rand_value,
   output logic                                rsp_strobe,
   output logic                                rsp_accepted,
   output logic                                rsp_class_index,
   output logic                                rsp_out_valid,
   output logic      [spq2_pkg::HANDLE_W-1:0]  rsp_out_handle,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [spq2_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spq2_pkg::CSR_DAT_W-1:0] csr_data
);

   logic [spq2_pkg::PORT_W-1:0] port_a_ff;
   logic [spq2_pkg::PORT_W-1:0] port_b_ff;
   logic [spq2_pkg::PROB_W-1:0] prob_a_ff;
   logic [spq2_pkg::PROB_W-1:0] prob_b_ff;

   logic busy_ff;
   logic strobe_ff, strobe_in;
   logic accepted_ff, accepted_in;
   logic class_ff, class_in;
   logic hit_ff, hit_in;

   logic item;
   logic enq_class;
   logic rand_lt_a;
   logic rand_lt_b;
   logic enq_full;

   spq2_pkg::fifo_ctl_type  high_ctl, low_ctl;
   spq2_pkg::fifo_stat_type high_stat, low_stat;
   logic [spq2_pkg::HANDLE_W-1:0] high_rd, low_rd;

   // Register port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_a_ff <= spq2_pkg::PORT_A_RESET;
         port_b_ff <= spq2_pkg::PORT_B_RESET;
         prob_a_ff <= spq2_pkg::PROB_ONE;
         prob_b_ff <= spq2_pkg::PROB_ONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spq2_pkg::CSR_PORT_A: port_a_ff <= csr_data[spq2_pkg::PORT_W-1:0];
            spq2_pkg::CSR_PORT_B: port_b_ff <= csr_data[spq2_pkg::PORT_W-1:0];
            spq2_pkg::CSR_PROB_A: prob_a_ff <= csr_data;
            spq2_pkg::CSR_PROB_B: prob_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Accept
   assign busy = reset | busy_ff;
   assign item = start && !busy;

   // Classifier: port A rule wins when both ports match
   assign rand_lt_a = {1'b0, req_rand_value} < prob_a_ff;
   assign rand_lt_b = {1'b0, req_rand_value} < prob_b_ff;

   always_comb begin
      if (req_dest_port == port_a_ff) begin
         enq_class = rand_lt_a ? spq2_pkg::CLS_HIGH : spq2_pkg::CLS_LOW;
      end else if (req_dest_port == port_b_ff) begin
         enq_class = rand_lt_b ? spq2_pkg::CLS_LOW : spq2_pkg::CLS_HIGH;
      end else begin
         enq_class = spq2_pkg::CLS_LOW;
      end
   end

   assign enq_full = (enq_class == spq2_pkg::CLS_HIGH) ? high_stat.full : low_stat.full;

   // Push and pop decisions, response fields
   always_comb begin
      high_ctl    = '0;
      low_ctl     = '0;
      accepted_in = 1'b0;
      class_in    = spq2_pkg::CLS_HIGH;
      hit_in      = 1'b0;
      strobe_in   = item;
      if (item) begin
         if (req_cmd == spq2_pkg::CMD_ENQ) begin
            class_in    = enq_class;
            accepted_in = !enq_full;
            if (enq_class == spq2_pkg::CLS_HIGH) begin
               high_ctl.push = !enq_full;
            end else begin
               low_ctl.push = !enq_full;
            end
         end else if (!high_stat.empty) begin
            high_ctl.pop = 1'b1;
            hit_in       = 1'b1;
         end else if (!low_stat.empty) begin
            low_ctl.pop = 1'b1;
            class_in    = spq2_pkg::CLS_LOW;
            hit_in      = 1'b1;
         end
      end
   end

   spq2_fifo u_high (
      .clock     (clock),
      .reset     (reset),
      .ctl       (high_ctl),
      .wr_handle (req_packet_handle),
      .stat      (high_stat),
      .rd_handle (high_rd)
   );

   spq2_fifo u_low (
      .clock     (clock),
      .reset     (reset),
      .ctl       (low_ctl),
      .wr_handle (req_packet_handle),
      .stat      (low_stat),
      .rd_handle (low_rd)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         strobe_ff <= strobe_in;
      end
      accepted_ff <= accepted_in;
      class_ff    <= class_in;
      hit_ff      <= hit_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_accepted    = strobe_ff & accepted_ff;
   assign rsp_class_index = strobe_ff & class_ff;
   assign rsp_out_valid   = strobe_ff & hit_ff;
   assign rsp_out_handle  = !rsp_out_valid ? '0 :
                            (class_ff == spq2_pkg::CLS_LOW) ? low_rd : high_rd;

endmodule

`default_nettype wire

[design/spq2_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq2_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           req_cmd,
   input wire logic                           rsp_strobe,
   input wire logic                           rsp_accepted,
   input wire logic                           rsp_out_valid,
   input wire logic [spq2_pkg::HANDLE_W-1:0]  rsp_out_handle
);

   // Every accepted beat yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("no response after accepted beat");

   // No response without an accepted beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset))
      else $error("response without accepted beat");

   // An enqueue never returns a packet, a dequeue never flags acceptance
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_accepted |-> !rsp_out_valid && $past(req_cmd) == spq2_pkg::CMD_ENQ)
      else $error("enqueue response carries a packet");

   // A served packet only comes from a dequeue
   a_deq_src: assert property (@(posedge clock) disable iff (reset)
      rsp_out_valid |-> rsp_strobe && $past(req_cmd) == spq2_pkg::CMD_DEQ)
      else $error("packet returned without dequeue");

   // Handle is zero when nothing was served
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_valid |-> rsp_out_handle == '0)
      else $error("nonzero handle without packet");

endmodule

bind strict_priority_two_class_queue_core spq2_checker u_spq2_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_strobe     (rsp_strobe),
   .rsp_accepted   (rsp_accepted),
   .rsp_out_valid  (rsp_out_valid),
   .rsp_out_handle (rsp_out_handle)
);

`default_nettype wire
